/* design/dds_pkg.sv */
// Shared constants, types and the microcode program of the dust density smoother.
package dds_pkg;

    localparam int SAMPLES  = 10;
    localparam int ADC_W    = 12;
    localparam int GAIN_W   = 16;
    localparam int ALPHA_W  = 9;
    localparam int OUT_W    = 20;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SUM_W  = $clog2(SAMPLES * 4095 + 1);
    localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int DVD_W  = PROD_W - 8;
    localparam int REC_SH = DVD_W + $clog2(SAMPLES);
    localparam int REC_W  = DVD_W + 1;
    localparam int QUO_W  = DVD_W + REC_W - REC_SH;
    localparam int DIFF_W = OUT_W + 1;
    localparam int EPROD_W = DIFF_W + ALPHA_W + 1;
    localparam int NS_W   = OUT_W + 4;
    localparam int UPC_W  = 4;

    // Rounded-up reciprocal of SAMPLES; exact floor division for any DVD_W-bit dividend.
    localparam logic [REC_W-1:0] REC_MUL =
        REC_W'(((64'd1 << REC_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    localparam logic [OUT_W-1:0]   OUT_MAX   = '1;
    localparam logic [ADC_W-1:0]   OFFSET_RST = 12'd372;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd8978;
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = 9'd26;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_EXCESS,
        OP_MUL,
        OP_DIV,
        OP_SAT,
        OP_DIFF,
        OP_EMAMUL,
        OP_EMIT
    } dds_op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_IF_LAST,
        C_IF_FREE
    } dds_cond_t;

    typedef struct packed {
        dds_op_t          op;
        dds_cond_t        cond;
        logic [UPC_W-1:0] target;
    } dds_uword_t;

    typedef struct packed {
        logic accept;
        logic last;
        logic out_free;
    } dds_stat_t;

    function automatic dds_uword_t dds_urom(input logic [UPC_W-1:0] addr);
        dds_uword_t w;
        case (addr)
            4'd0: w = '{op: OP_IDLE,    cond: C_IF_LAST, target: 4'd1};
            4'd1: w = '{op: OP_EXCESS,  cond: C_NEXT,    target: 4'd0};
            4'd2: w = '{op: OP_MUL,     cond: C_NEXT,    target: 4'd0};
            4'd3: w = '{op: OP_DIV,     cond: C_NEXT,    target: 4'd0};
            4'd4: w = '{op: OP_SAT,     cond: C_NEXT,    target: 4'd0};
            4'd5: w = '{op: OP_DIFF,    cond: C_NEXT,    target: 4'd0};
            4'd6: w = '{op: OP_EMAMUL,  cond: C_NEXT,    target: 4'd0};
            4'd7: w = '{op: OP_EMIT,    cond: C_IF_FREE, target: 4'd0};
            default: w = '{op: OP_IDLE, cond: C_IF_FREE, target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

/* design/dds_seq.sv */
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module dds_seq
    import dds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dds_stat_t stat,
    output dds_op_t   op
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    dds_uword_t       uword;

    assign uword = dds_urom(upc_reg);
    assign op    = uword.op;

    always_comb begin
        case (uword.cond)
            C_NEXT:    upc_next = upc_reg + UPC_W'(1);
            C_IF_LAST: upc_next = (stat.accept && stat.last) ? uword.target : upc_reg;
            C_IF_FREE: upc_next = stat.out_free ? uword.target : upc_reg;
            default:   upc_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= '0;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* design/dds_dp.sv */
// Datapath: sample accumulation, batch density, reciprocal divide, moving average and output register.
module dds_dp
    import dds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dds_op_t              op,
    output dds_stat_t            stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADC_W-1:0]     s_adc_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_smoothed_density,
    output logic [OUT_W-1:0]     m_instant_density
);

    logic [ADC_W-1:0]         offset_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [OUT_W-1:0]         smooth_reg;
    logic [SUM_W-1:0]         exc_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [OUT_W-1:0]         d_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [EPROD_W-1:0] eprod_reg;
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_smooth_reg;
    logic [OUT_W-1:0]         m_inst_reg;

    logic                     accept;
    logic                     last;
    logic                     out_free;
    logic [SUM_W-1:0]         base;
    logic [SUM_W-1:0]         exc_next;
    logic [DVD_W+REC_W-1:0]   rec_prod;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [NS_W-1:0]   ns;
    logic [OUT_W-1:0]         smooth_next;

    assign s_ready  = (op == OP_IDLE);
    assign accept   = s_valid && s_ready;
    assign last     = (idx_reg == IDX_W'(SAMPLES - 1));
    assign out_free = !m_valid_reg || m_ready;

    assign stat.accept   = accept;
    assign stat.last     = last;
    assign stat.out_free = out_free;

    assign base     = SUM_W'(offset_reg) * SUM_W'(SAMPLES);
    assign exc_next = (sum_reg > base) ? (sum_reg - base) : '0;

    assign rec_prod = (DVD_W + REC_W)'(prod_reg[PROD_W-1:8]) * (DVD_W + REC_W)'(REC_MUL);

    assign alpha_s = {1'b0, alpha_reg};
    assign ns = $signed({{(NS_W - OUT_W){1'b0}}, smooth_reg})
              + {{(NS_W - (EPROD_W - 8)){eprod_reg[EPROD_W-1]}}, eprod_reg[EPROD_W-1:8]};

    always_comb begin
        if (ns < 0) begin
            smooth_next = '0;
        end else if (ns > $signed({{(NS_W - OUT_W){1'b0}}, OUT_MAX})) begin
            smooth_next = OUT_MAX;
        end else begin
            smooth_next = ns[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RST;
            gain_reg   <= GAIN_RST;
            alpha_reg  <= ALPHA_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OFFSET: offset_reg <= cfg_wdata[ADC_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_ALPHA:  alpha_reg  <= cfg_wdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            idx_reg     <= '0;
            smooth_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                sum_reg <= sum_reg + SUM_W'(s_adc_sample);
                idx_reg <= last ? '0 : idx_reg + IDX_W'(1);
            end else if (op == OP_EXCESS) begin
                sum_reg <= '0;
            end
            if (op == OP_EMIT && out_free) begin
                smooth_reg  <= smooth_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_EXCESS: exc_reg <= exc_next;
            OP_MUL:    prod_reg <= PROD_W'(exc_reg) * PROD_W'(gain_reg);
            OP_DIV:    quo_reg <= rec_prod[REC_SH +: QUO_W];
            OP_SAT: d_reg <= (quo_reg > QUO_W'(OUT_MAX)) ? OUT_MAX : quo_reg[OUT_W-1:0];
            OP_DIFF: diff_reg <= $signed({1'b0, d_reg}) - $signed({1'b0, smooth_reg});
            OP_EMAMUL: eprod_reg <= EPROD_W'(alpha_s) * EPROD_W'(diff_reg);
            OP_EMIT: begin
                if (out_free) begin
                    m_smooth_reg <= smooth_next;
                    m_inst_reg   <= d_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_smoothed_density = m_smooth_reg;
    assign m_instant_density  = m_inst_reg;

endmodule

/* design/dust_density_average_smooth.sv */
// Top level of the dust density averaging and smoothing block.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_adc_sample
//  m_        out        m_valid/m_ready    m_smoothed_density, m_instant_density
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// A sample that does not close a batch is added to the sum, and the block stays ready for the next sample.
// A sample that closes a batch is followed by seven program steps, during which no sample is taken.
// Reset is synchronous and active low; it restores the register defaults.
// A result waiting in the output register stalls the program only at its final step.
module dust_density_average_smooth
    import dds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADC_W-1:0]     s_adc_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_smoothed_density,
    output logic [OUT_W-1:0]     m_instant_density
);

    dds_op_t   op;
    dds_stat_t stat;

    dds_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .op      (op)
    );

    dds_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op                 (op),
        .stat               (stat),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_adc_sample       (s_adc_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_smoothed_density (m_smoothed_density),
        .m_instant_density  (m_instant_density)
    );

endmodule

/* design/dds_checker.sv */
// Port-level checker for the dust density smoother and its bind to the top level.
module dds_checker
    import dds_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_smoothed_density,
    input logic [OUT_W-1:0] m_instant_density
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed_density)
            && $stable(m_instant_density))
        else $error("Stalled result changed.");

    // A new result appears only after a batch was being computed.
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("Result appeared while the block was ready for samples.");

    // Without an input transfer the block stays ready.
    a_idle_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready)
        else $error("Ready dropped without an input transfer.");

    // Once ready falls, it stays low in the next cycle too.
    a_busy_span: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |=> !s_ready)
        else $error("Batch computation ended too early.");

endmodule

bind dust_density_average_smooth dds_checker u_dds_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_smoothed_density (m_smoothed_density),
    .m_instant_density  (m_instant_density)
);

/* tb/tb_dust_density_average_smooth.sv */
// Self-checking testbench for the dust density averaging and smoothing block.
module tb_dust_density_average_smooth;
    import dds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [OUT_W-1:0] smoothed;
        logic [OUT_W-1:0] instant;
    } density_pair_t;

    class density_tracker;
        logic [ADC_W-1:0]   offset;
        logic [GAIN_W-1:0]  gain;
        logic [ALPHA_W-1:0] alpha;
        logic [SUM_W-1:0]   batch_sum;
        int unsigned        batch_count;
        logic [OUT_W-1:0]   average;
        density_pair_t      awaited[$];
        int unsigned        errors;

        function new();
            offset = OFFSET_RST;
            gain = GAIN_RST;
            alpha = ALPHA_RST;
            batch_sum = '0;
            batch_count = 0;
            average = '0;
            errors = 0;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_OFFSET: offset = value[ADC_W-1:0];
                REG_GAIN: gain = value[GAIN_W-1:0];
                REG_ALPHA: alpha = value[ALPHA_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_sample(logic [ADC_W-1:0] sample);
            longint excess;
            longint density;
            longint step;
            longint next_avg;
            density_pair_t pair;
            batch_sum = batch_sum + SUM_W'(sample);
            batch_count++;
            if (batch_count < SAMPLES)
                return;
            excess = longint'(batch_sum) - longint'(offset) * SAMPLES;
            density = (excess > 0) ? (excess * longint'(gain)) / (SAMPLES * 256) : 0;
            if (density > longint'(OUT_MAX))
                density = longint'(OUT_MAX);
            step = (longint'(alpha) * (density - longint'(average))) >>> 8;
            next_avg = longint'(average) + step;
            if (next_avg < 0)
                next_avg = 0;
            if (next_avg > longint'(OUT_MAX))
                next_avg = longint'(OUT_MAX);
            average = next_avg[OUT_W-1:0];
            pair.smoothed = average;
            pair.instant = density[OUT_W-1:0];
            awaited.push_back(pair);
            batch_sum = '0;
            batch_count = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        task report(string what, longint got, longint want);
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] smoothed_got, logic [OUT_W-1:0] instant_got);
            density_pair_t want;
            if (awaited.size() == 0) begin
                report("result transfer with nothing expected", smoothed_got, 0);
                return;
            end
            want = awaited.pop_front();
            if (smoothed_got !== want.smoothed)
                report("smoothed_density", smoothed_got, want.smoothed);
            if (instant_got !== want.instant)
                report("instant_density", instant_got, want.instant);
        endtask

        task report_leftover();
            if (awaited.size() != 0)
                report("results never delivered", awaited.size(), 0);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ADC_W-1:0]     s_adc_sample = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_W-1:0]     m_smoothed_density;
    logic [OUT_W-1:0]     m_instant_density;

    density_tracker tracker;
    bit calm = 1'b0;

    dust_density_average_smooth DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_adc_sample       (s_adc_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_smoothed_density (m_smoothed_density),
        .m_instant_density  (m_instant_density)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample(logic [ADC_W-1:0] base);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 4095;
            2, 3, 4: v = int'(base) + int'($urandom_range(0, 200)) - 100;
            default: v = int'($urandom_range(0, 4095));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[ADC_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] pick_alpha();
        if ($urandom_range(0, 3) != 0)
            return CFG_W'($urandom_range(0, 256));
        return CFG_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_sample(logic [ADC_W-1:0] sample);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_adc_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        tracker.add_sample(sample);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tracker.note_register(idx, value);
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] offset, logic [CFG_W-1:0] gain,
                                  logic [CFG_W-1:0] alpha);
        write_reg(REG_OFFSET, offset);
        write_reg(REG_GAIN, gain);
        write_reg(REG_ALPHA, alpha);
        cfg_wr_en <= 1'b0;
    endtask

    // The block must be idle before its registers change.
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_smoothed_density, m_instant_density);
    end

    initial begin
        int unsigned n;
        forever begin
            n = idle_len();
            if (n == 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("dust_density_average_smooth regression: fail");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned k;
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write past the last register must change nothing.
        write_reg(REG_UNUSED, 16'hFFFF);
        apply_settings(16'd0, 16'hFFFF, 16'd511);
        repeat (SAMPLES) send_sample(12'hFFF);
        repeat (SAMPLES) send_sample(12'h000);
        repeat (SAMPLES / 2) send_sample(12'd100);
        settle();
        apply_settings(16'd100, 16'hFFFF, 16'd256);
        repeat (SAMPLES - SAMPLES / 2) send_sample(12'd100);

        for (phase = 0; phase < 12; phase++) begin
            settle();
            case (phase)
                0: apply_settings(16'd4095, 16'd0, 16'd0);
                1: apply_settings(16'd0, 16'd65535, 16'd256);
                2: apply_settings(16'd372, 16'd8978, 16'd26);
                3: apply_settings(16'd4095, 16'd65535, 16'd511);
                default: apply_settings(CFG_W'($urandom_range(0, 65535)),
                                        CFG_W'($urandom_range(0, 65535)), pick_alpha());
            endcase
            calm = (phase == 5);
            for (k = 0; k < 50; k++) begin
                send_sample(pick_sample(tracker.offset));
                if (k == 23 && phase[0]) begin
                    settle();
                    apply_settings(CFG_W'($urandom_range(0, 4095)),
                                   CFG_W'($urandom_range(0, 65535)), pick_alpha());
                end
            end
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        for (k = 0; k < 50000 && tracker.pending() != 0; k++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        tracker.report_leftover();
        if (tracker.errors == 0)
            $display("dust_density_average_smooth regression: pass");
        else
            $display("dust_density_average_smooth regression: fail");
        $finish;
    end

endmodule
